/* hdl/ght_pkg.sv */
package ght_pkg;

   // Default table geometry.
   localparam int SLOT_COUNT_DEF = 512;
   localparam int SLOT_BITS_DEF  = 9;

   // Width of a request handle.
   localparam int ID_BITS = 31;

   // Command codes.
   localparam logic [2:0] CMD_ALLOCATE = 3'd0;
   localparam logic [2:0] CMD_COMPLETE = 3'd1;
   localparam logic [2:0] CMD_CANCEL   = 3'd2;
   localparam logic [2:0] CMD_DELETE   = 3'd3;
   localparam logic [2:0] CMD_POLL     = 3'd4;
   localparam logic [2:0] CMD_REMOVE   = 3'd5;

   // Status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_INVALID   = 3'd1;
   localparam logic [2:0] ST_BUSY      = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_BAD_COUNT = 3'd4;

   // Request states.
   localparam logic [1:0] RQ_PROCESSING = 2'd0;
   localparam logic [1:0] RQ_COMPLETED  = 2'd1;
   localparam logic [1:0] RQ_ABORTED    = 2'd2;

   typedef enum logic [1:0] {
      CTL_CLEAR,
      CTL_IDLE,
      CTL_EXEC
   } ctl_state_type;

endpackage

/* hdl/generational_request_handle_table.sv */
// Generational request handle table.
// A word on the req_ channel carries one command: allocate, complete, cancel,
// delete, poll or remove. Every command gives exactly one word on the rsp_
// channel. Handles are a generation tag above the slot number; a handle is
// honored only if its slot is valid and the generations match exactly.
// Entries live in one synchronous memory of SLOT_COUNT words; a command reads
// its entry when it is accepted and, if it changes it, writes it back when its
// result is committed. A new command is not accepted until the one in hand has
// its result. An allocate scans the slots round robin, skipping busy slots, and
// answers with a full status once it has tried every slot but slot zero.
// The result sits in an output register, so the next word is accepted while
// a result still waits. If rsp_stall is held, the block finishes the next
// command up to its result and then holds req_stall high until the output
// register frees up.
// After reset, a clearing pass writes every entry, one per cycle; req_stall
// stays high during that pass.
module generational_request_handle_table #(
   parameter int SLOT_COUNT = ght_pkg::SLOT_COUNT_DEF,
   parameter int SLOT_BITS  = ght_pkg::SLOT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_command,
   input  logic [ght_pkg::ID_BITS-1:0]  req_request_id,
   input  logic [15:0]                  req_request_count,
   input  logic                         req_fail_aborts,
   input  logic                         req_op_failed,
   input  logic                         req_op_canceled,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_status,
   output logic [ght_pkg::ID_BITS-1:0]  rsp_new_id,
   output logic [1:0]                   rsp_request_state,
   output logic                         rsp_command_aborted,
   output logic                         rsp_command_canceled,
   output logic                         rsp_request_done
);

   localparam int GEN_BITS = ght_pkg::ID_BITS - SLOT_BITS;
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOT_COUNT - 1);
   localparam logic [SLOT_BITS-1:0] LAST_TRY  = SLOT_BITS'(SLOT_COUNT - 2);
   localparam logic [SLOT_BITS:0]   COUNT_EXT = (SLOT_BITS + 1)'(SLOT_COUNT);

   typedef struct packed {
      logic                valid;
      logic [GEN_BITS-1:0] generation;
      logic [1:0]          state;
      logic [15:0]         remaining;
      logic                cancel_flag;
      logic                abort_mode;
   } entry_type;

   ght_pkg::ctl_state_type state_ff, state_in;

   entry_type entry_mem [SLOT_COUNT];
   entry_type rd_entry_ff;
   entry_type wr_entry;
   logic [SLOT_BITS-1:0] rd_addr;
   logic [SLOT_BITS-1:0] wr_addr;
   logic                 wr_en;

   // Command being worked on.
   logic [2:0]                  cmd_ff;
   logic [ght_pkg::ID_BITS-1:0] id_ff;
   logic [15:0]                 count_ff;
   logic                        abort_ff;
   logic                        failed_ff;
   logic                        canceled_ff;

   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [SLOT_BITS-1:0] scan_ptr_ff, scan_ptr_in;
   logic [SLOT_BITS-1:0] try_ff, try_in;
   logic [SLOT_BITS-1:0] clr_ff, clr_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [2:0]                  rsp_status_ff;
   logic [ght_pkg::ID_BITS-1:0] rsp_new_id_ff;
   logic [1:0]                  rsp_state_ff;
   logic                        rsp_aborted_ff;
   logic                        rsp_canceled_ff;
   logic                        rsp_done_ff;

   logic accept;
   logic clr_en;
   logic exec_en;
   logic out_free;
   logic finish;
   logic commit;
   logic scan_step;
   logic ptr_adv;
   logic entry_write;

   logic [SLOT_BITS-1:0] req_slot;
   logic                 req_in_range;
   logic                 slot_in_range;
   logic [SLOT_BITS-1:0] mem_slot;
   logic [SLOT_BITS-1:0] scan_next;
   logic                 slot_free;
   logic                 hit;
   logic                 cancel_any;
   logic [15:0]          rem_dec;
   logic [GEN_BITS-1:0]  gen_next;

   logic [2:0]                  res_status;
   logic [ght_pkg::ID_BITS-1:0] res_new_id;
   logic [1:0]                  res_state;
   logic                        res_aborted;
   logic                        res_canceled;
   logic                        res_done;

   // FSM: next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ght_pkg::CTL_CLEAR: begin
            if (clr_ff == LAST_SLOT) begin
               state_in = ght_pkg::CTL_IDLE;
            end
         end
         ght_pkg::CTL_IDLE: begin
            if (accept) begin
               state_in = ght_pkg::CTL_EXEC;
            end
         end
         ght_pkg::CTL_EXEC: begin
            if (commit) begin
               state_in = ght_pkg::CTL_IDLE;
            end
         end
         default: state_in = ght_pkg::CTL_CLEAR;
      endcase
   end

   // FSM: outputs.
   always_comb begin
      req_stall = 1'b1;
      clr_en    = 1'b0;
      exec_en   = 1'b0;
      unique case (state_ff)
         ght_pkg::CTL_CLEAR: clr_en = 1'b1;
         ght_pkg::CTL_IDLE:  req_stall = 1'b0;
         ght_pkg::CTL_EXEC:  exec_en = 1'b1;
         default:            req_stall = 1'b1;
      endcase
   end

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign commit   = exec_en && finish && out_free;

   assign req_slot      = req_request_id[SLOT_BITS-1:0];
   assign req_in_range  = {1'b0, req_slot} < COUNT_EXT;
   assign slot_in_range = {1'b0, slot_ff} < COUNT_EXT;
   assign mem_slot      = slot_in_range ? slot_ff : '0;
   assign scan_next     = (slot_ff >= LAST_SLOT) ? SLOT_BITS'(1) : slot_ff + SLOT_BITS'(1);

   assign slot_free  = !(rd_entry_ff.valid && rd_entry_ff.state == ght_pkg::RQ_PROCESSING);
   assign hit        = (id_ff != '0) && (slot_ff != '0) && slot_in_range && rd_entry_ff.valid
                       && (id_ff[ght_pkg::ID_BITS-1:SLOT_BITS] == rd_entry_ff.generation);
   assign cancel_any = canceled_ff || rd_entry_ff.cancel_flag;
   assign rem_dec    = rd_entry_ff.remaining - 16'd1;
   // The generation wraps from its largest value back to one, never to zero.
   assign gen_next   = (&rd_entry_ff.generation) ? GEN_BITS'(1)
                                                 : rd_entry_ff.generation + GEN_BITS'(1);

   // Command execution on the entry read at acceptance or, for an allocate, at each scan step.
   always_comb begin
      finish       = 1'b0;
      scan_step    = 1'b0;
      ptr_adv      = 1'b0;
      entry_write  = 1'b0;
      wr_entry     = rd_entry_ff;
      res_status   = ght_pkg::ST_INVALID;
      res_new_id   = '0;
      res_state    = ght_pkg::RQ_PROCESSING;
      res_aborted  = 1'b0;
      res_canceled = 1'b0;
      res_done     = 1'b0;
      if (cmd_ff == ght_pkg::CMD_ALLOCATE) begin
         if (count_ff == '0) begin
            finish     = 1'b1;
            res_status = ght_pkg::ST_BAD_COUNT;
         end else if (slot_free) begin
            finish                  = 1'b1;
            ptr_adv                 = 1'b1;
            entry_write             = 1'b1;
            wr_entry.valid          = 1'b1;
            wr_entry.generation     = gen_next;
            wr_entry.state          = ght_pkg::RQ_PROCESSING;
            wr_entry.remaining      = count_ff;
            wr_entry.cancel_flag    = 1'b0;
            wr_entry.abort_mode     = abort_ff;
            res_status              = ght_pkg::ST_OK;
            res_new_id              = {gen_next, slot_ff};
         end else if (try_ff == LAST_TRY) begin
            finish     = 1'b1;
            ptr_adv    = 1'b1;
            res_status = ght_pkg::ST_FULL;
         end else begin
            // The scan only moves while a command is being worked on.
            scan_step = exec_en;
         end
      end else begin
         finish = 1'b1;
         if (hit) begin
            res_status = ght_pkg::ST_OK;
            case (cmd_ff)
               ght_pkg::CMD_COMPLETE: begin
                  entry_write  = 1'b1;
                  res_canceled = cancel_any;
                  res_aborted  = cancel_any || failed_ff;
                  if (rd_entry_ff.remaining != '0) begin
                     wr_entry.remaining = rem_dec;
                     if (rem_dec == '0) begin
                        res_done = 1'b1;
                        wr_entry.state = (cancel_any || (failed_ff && rd_entry_ff.abort_mode))
                                         ? ght_pkg::RQ_ABORTED : ght_pkg::RQ_COMPLETED;
                     end
                  end
                  res_state = wr_entry.state;
               end
               ght_pkg::CMD_CANCEL: begin
                  entry_write = 1'b1;
                  if (rd_entry_ff.state == ght_pkg::RQ_PROCESSING) begin
                     wr_entry.cancel_flag = 1'b1;
                  end
                  res_state = rd_entry_ff.state;
               end
               ght_pkg::CMD_DELETE: begin
                  if (rd_entry_ff.state == ght_pkg::RQ_PROCESSING) begin
                     res_status = ght_pkg::ST_BUSY;
                  end else begin
                     entry_write    = 1'b1;
                     wr_entry.valid = 1'b0;
                  end
               end
               ght_pkg::CMD_POLL: begin
                  res_state = rd_entry_ff.state;
               end
               ght_pkg::CMD_REMOVE: begin
                  entry_write    = 1'b1;
                  wr_entry.valid = 1'b0;
               end
               default: begin
                  res_status = ght_pkg::ST_INVALID;
               end
            endcase
         end
      end
   end

   // Memory port control.
   always_comb begin
      wr_en   = clr_en || (commit && entry_write);
      wr_addr = clr_en ? clr_ff : mem_slot;
      if (!exec_en) begin
         if (req_command == ght_pkg::CMD_ALLOCATE) begin
            rd_addr = scan_ptr_ff;
         end else begin
            rd_addr = req_in_range ? req_slot : '0;
         end
      end else if (scan_step) begin
         rd_addr = scan_next;
      end else begin
         rd_addr = mem_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= clr_en ? '0 : wr_entry;
      end
      rd_entry_ff <= entry_mem[rd_addr];
   end

   // Scan and command registers.
   always_comb begin
      slot_in     = slot_ff;
      try_in      = try_ff;
      scan_ptr_in = scan_ptr_ff;
      clr_in      = clr_en ? clr_ff + SLOT_BITS'(1) : clr_ff;
      if (accept) begin
         slot_in = (req_command == ght_pkg::CMD_ALLOCATE) ? scan_ptr_ff : req_slot;
         try_in  = '0;
      end else if (scan_step) begin
         slot_in = scan_next;
         try_in  = try_ff + SLOT_BITS'(1);
      end
      if (scan_step || (commit && ptr_adv)) begin
         scan_ptr_in = scan_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ght_pkg::CTL_CLEAR;
         scan_ptr_ff <= SLOT_BITS'(1);
         clr_ff      <= '0;
         try_ff      <= '0;
         slot_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         scan_ptr_ff <= scan_ptr_in;
         clr_ff      <= clr_in;
         try_ff      <= try_in;
         slot_ff     <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_command;
         id_ff       <= req_request_id;
         count_ff    <= req_request_count;
         abort_ff    <= req_fail_aborts;
         failed_ff   <= req_op_failed;
         canceled_ff <= req_op_canceled;
      end
   end

   // Output register.
   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff   <= res_status;
         rsp_new_id_ff   <= res_new_id;
         rsp_state_ff    <= res_state;
         rsp_aborted_ff  <= res_aborted;
         rsp_canceled_ff <= res_canceled;
         rsp_done_ff     <= res_done;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_new_id           = rsp_new_id_ff;
   assign rsp_request_state    = rsp_state_ff;
   assign rsp_command_aborted  = rsp_aborted_ff;
   assign rsp_command_canceled = rsp_canceled_ff;
   assign rsp_request_done     = rsp_done_ff;

endmodule

/* hdl/ght_checker.sv */
module ght_checker #(
   parameter int SLOT_BITS = ght_pkg::SLOT_BITS_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [2:0]                  rsp_status,
   input logic [ght_pkg::ID_BITS-1:0] rsp_new_id,
   input logic [1:0]                  rsp_request_state,
   input logic                        rsp_command_aborted,
   input logic                        rsp_command_canceled,
   input logic                        rsp_request_done
);

   // A held result word keeps its status, handle, request state and done flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_new_id)
         && $stable(rsp_request_state) && $stable(rsp_request_done))
      else $error("result word changed while stalled");

   // The table is being cleared right after reset and takes no command.
   assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("command port open during clearing pass");

   // A failed command reports nothing but its status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ght_pkg::ST_OK |-> rsp_new_id == '0
         && rsp_request_state == ght_pkg::RQ_PROCESSING && !rsp_command_aborted
         && !rsp_command_canceled && !rsp_request_done)
      else $error("failed command carries result fields");

   // The last completion always settles the request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_request_done |-> rsp_status == ght_pkg::ST_OK
         && rsp_request_state != ght_pkg::RQ_PROCESSING)
      else $error("request done but not settled");

   // A handle given out never names slot zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_id != '0 |-> rsp_status == ght_pkg::ST_OK
         && rsp_new_id[SLOT_BITS-1:0] != '0)
      else $error("handle with slot zero given out");

endmodule

bind generational_request_handle_table ght_checker #(.SLOT_BITS(SLOT_BITS)) u_ght_checker (.*);

/* dv/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS  = ght_pkg::SLOT_COUNT_DEF;
   localparam int SLOT_W = ght_pkg::SLOT_BITS_DEF;
   localparam int ID_W   = ght_pkg::ID_BITS;
   localparam int GEN_W  = ID_W - SLOT_W;
   localparam int SETTLE_CYCLES = 32;

   // Command codes the block does not define; it must reject them.
   localparam logic [2:0] CMD_RESERVED_A = 3'd6;
   localparam logic [2:0] CMD_RESERVED_B = 3'd7;

   typedef struct packed {
      logic [2:0]      command;
      logic [ID_W-1:0] request_id;
      logic [15:0]     request_count;
      logic            fail_aborts;
      logic            op_failed;
      logic            op_canceled;
   } request_type;

   typedef struct packed {
      logic [2:0]      status;
      logic [ID_W-1:0] new_id;
      logic [1:0]      request_state;
      logic            command_aborted;
      logic            command_canceled;
      logic            request_done;
   } result_type;

   class handle_table_board;
      bit             used[SLOTS];
      bit [GEN_W-1:0] gen[SLOTS];
      bit [1:0]       phase[SLOTS];
      bit [15:0]      left[SLOTS];
      bit             cancel_req[SLOTS];
      bit             abort_mode[SLOTS];
      int             scan_ptr;
      result_type     expected_q[$];
      bit [ID_W-1:0]  last_new_id;
      int errors, n_requests, n_results, n_full, n_settled;

      function new();
         scan_ptr = 1;
      endfunction

      function bit [ID_W-1:0] handle_of(int s);
         return {gen[s], s[SLOT_W-1:0]};
      endfunction

      // Returns the slot a handle names, or zero when the handle is refused.
      function int lookup(bit [ID_W-1:0] id);
         int s;
         s = int'(id[SLOT_W-1:0]);
         if (id == 0 || s == 0 || s >= SLOTS || !used[s]) return 0;
         if (id[ID_W-1:SLOT_W] != gen[s]) return 0;
         return s;
      endfunction

      function void note_request(request_type w);
         result_type   r;
         int           s;
         bit [GEN_W:0] g;
         bit           c;
         r = '0;
         r.status = ght_pkg::ST_INVALID;
         n_requests++;
         if (w.command == ght_pkg::CMD_ALLOCATE) begin
            if (w.request_count == 0) begin
               r.status = ght_pkg::ST_BAD_COUNT;
            end else begin
               r.status = ght_pkg::ST_FULL;
               for (int n = 0; n < SLOTS - 1; n++) begin
                  s = scan_ptr;
                  scan_ptr = (scan_ptr >= SLOTS - 1) ? 1 : scan_ptr + 1;
                  if (used[s] && phase[s] == ght_pkg::RQ_PROCESSING) continue;
                  g = {1'b0, gen[s]} + (GEN_W + 1)'(1);
                  if (g[GEN_W]) g = (GEN_W + 1)'(1);
                  gen[s] = g[GEN_W-1:0];
                  used[s] = 1'b1;
                  phase[s] = ght_pkg::RQ_PROCESSING;
                  left[s] = w.request_count;
                  cancel_req[s] = 1'b0;
                  abort_mode[s] = w.fail_aborts;
                  r.status = ght_pkg::ST_OK;
                  r.new_id = handle_of(s);
                  last_new_id = r.new_id;
                  break;
               end
               if (r.status == ght_pkg::ST_FULL) n_full++;
            end
         end else if (w.command <= ght_pkg::CMD_REMOVE) begin
            s = lookup(w.request_id);
            if (s != 0) begin
               r.status = ght_pkg::ST_OK;
               case (w.command)
                  ght_pkg::CMD_COMPLETE: begin
                     c = w.op_canceled | cancel_req[s];
                     r.command_canceled = c;
                     r.command_aborted = c | w.op_failed;
                     // Completions past the last one report an outcome only.
                     if (left[s] != 0) begin
                        left[s]--;
                        if (left[s] == 0) begin
                           r.request_done = 1'b1;
                           n_settled++;
                           phase[s] = (c | (w.op_failed & abort_mode[s])) ?
                                      ght_pkg::RQ_ABORTED : ght_pkg::RQ_COMPLETED;
                        end
                     end
                     r.request_state = phase[s];
                  end
                  ght_pkg::CMD_CANCEL: begin
                     if (phase[s] == ght_pkg::RQ_PROCESSING) cancel_req[s] = 1'b1;
                     r.request_state = phase[s];
                  end
                  ght_pkg::CMD_DELETE: begin
                     if (phase[s] == ght_pkg::RQ_PROCESSING) r.status = ght_pkg::ST_BUSY;
                     else used[s] = 1'b0;
                  end
                  ght_pkg::CMD_POLL: begin
                     r.request_state = phase[s];
                  end
                  ght_pkg::CMD_REMOVE: begin
                     used[s] = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         expected_q = {expected_q, r};
      endfunction

      task report(string what, longint unsigned got_v, longint unsigned exp_v);
         errors++;
         $display("ERROR: result %0d %s: got 0x%0h, expected 0x%0h",
                  n_results, what, got_v, exp_v);
      endtask

      task check_result(result_type got);
         result_type exp;
         n_results++;
         if (expected_q.size() == 0) begin
            report("arrived with nothing outstanding, status", got.status, 0);
            return;
         end
         exp = expected_q[0];
         expected_q.delete(0);
         if (got.status !== exp.status) report("status", got.status, exp.status);
         if (got.new_id !== exp.new_id) report("new_id", got.new_id, exp.new_id);
         if (got.request_state !== exp.request_state)
            report("request_state", got.request_state, exp.request_state);
         if (got.command_aborted !== exp.command_aborted)
            report("command_aborted", got.command_aborted, exp.command_aborted);
         if (got.command_canceled !== exp.command_canceled)
            report("command_canceled", got.command_canceled, exp.command_canceled);
         if (got.request_done !== exp.request_done)
            report("request_done", got.request_done, exp.request_done);
      endtask
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   logic [2:0]      req_command = ght_pkg::CMD_POLL;
   logic [ID_W-1:0] req_request_id = '0;
   logic [15:0]     req_request_count = '0;
   logic            req_fail_aborts = 1'b0;
   logic            req_op_failed = 1'b0;
   logic            req_op_canceled = 1'b0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   logic [2:0]      rsp_status;
   logic [ID_W-1:0] rsp_new_id;
   logic [1:0]      rsp_request_state;
   logic            rsp_command_aborted;
   logic            rsp_command_canceled;
   logic            rsp_request_done;

   int gap_pct = 0;
   int stall_pct = 0;

   handle_table_board board = new();

   generational_request_handle_table dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_request_id       (req_request_id),
      .req_request_count    (req_request_count),
      .req_fail_aborts      (req_fail_aborts),
      .req_op_failed        (req_op_failed),
      .req_op_canceled      (req_op_canceled),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_new_id           (rsp_new_id),
      .rsp_request_state    (rsp_request_state),
      .rsp_command_aborted  (rsp_command_aborted),
      .rsp_command_canceled (rsp_command_canceled),
      .rsp_request_done     (rsp_request_done)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         board.check_result({rsp_status, rsp_new_id, rsp_request_state,
                             rsp_command_aborted, rsp_command_canceled,
                             rsp_request_done});
   end

   initial begin
      #40ms;
      $display("tb_top failed");
      $finish;
   end

   // Drives one word and returns at the edge where the block takes it.
   task automatic send_word(logic [2:0] cmd, logic [ID_W-1:0] id,
                            logic [15:0] count, bit abort_err, bit failed,
                            bit canceled);
      request_type w;
      w = {cmd, id, count, abort_err, failed, canceled};
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_command = cmd;
      req_request_id = id;
      req_request_count = count;
      req_fail_aborts = abort_err;
      req_op_failed = failed;
      req_op_canceled = canceled;
      do @(posedge clock); while (req_stall);
      board.note_request(w);
   endtask

   task automatic pause_sender();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
   endtask

   function automatic int busy_slots();
      int n;
      n = 0;
      for (int s = 1; s < SLOTS; s++)
         if (board.used[s] && board.phase[s] == ght_pkg::RQ_PROCESSING) n++;
      return n;
   endfunction

   // Picks a slot holding a live handle, favoring open requests when asked.
   function automatic int live_slot(bit want_busy);
      int busy_q[$];
      int any_q[$];
      for (int s = 1; s < SLOTS; s++) begin
         if (board.used[s]) begin
            any_q = {any_q, s};
            if (board.phase[s] == ght_pkg::RQ_PROCESSING) busy_q = {busy_q, s};
         end
      end
      if (want_busy && busy_q.size() != 0 && $urandom_range(4) != 0)
         return busy_q[$urandom_range(busy_q.size() - 1)];
      if (any_q.size() == 0) return 0;
      return any_q[$urandom_range(any_q.size() - 1)];
   endfunction

   task automatic directed_checks();
      logic [ID_W-1:0] h_a, h_b, h_c, h_d;
      send_word(ght_pkg::CMD_POLL, '0, 16'd0, 0, 0, 0);
      send_word(ght_pkg::CMD_ALLOCATE, '0, 16'd0, 0, 0, 0);
      send_word(ght_pkg::CMD_ALLOCATE, '0, 16'd1, 0, 0, 0);
      h_a = board.last_new_id;
      send_word(ght_pkg::CMD_ALLOCATE, '1, 16'hFFFF, 1, 1, 1);
      h_b = board.last_new_id;
      send_word(ght_pkg::CMD_ALLOCATE, '0, 16'd2, 1, 0, 0);
      h_c = board.last_new_id;
      send_word(ght_pkg::CMD_POLL, h_a, 16'd0, 0, 0, 0);
      send_word(ght_pkg::CMD_COMPLETE, h_a, 16'd0, 0, 0, 0);
      send_word(ght_pkg::CMD_COMPLETE, h_a, '1, 1, 1, 0);
      send_word(ght_pkg::CMD_CANCEL, h_a, 16'd0, 0, 0, 0);
      send_word(ght_pkg::CMD_DELETE, h_b, 16'd0, 0, 0, 0);
      send_word(ght_pkg::CMD_CANCEL, h_b, 16'd0, 0, 0, 0);
      send_word(ght_pkg::CMD_COMPLETE, h_b, 16'd0, 0, 0, 0);
      send_word(ght_pkg::CMD_COMPLETE, h_c, 16'd0, 0, 1, 0);
      send_word(ght_pkg::CMD_COMPLETE, h_c, 16'd0, 0, 0, 1);
      send_word(ght_pkg::CMD_DELETE, h_c, 16'd0, 0, 0, 0);
      send_word(ght_pkg::CMD_POLL, h_c, 16'd0, 0, 0, 0);
      send_word(ght_pkg::CMD_REMOVE, h_b, 16'd0, 0, 0, 0);
      send_word(CMD_RESERVED_A, h_a, 16'd1, 1, 1, 1);
      send_word(CMD_RESERVED_B, h_a, 16'd1, 1, 1, 1);
      send_word(ght_pkg::CMD_POLL, {h_a[ID_W-1:SLOT_W], SLOT_W'(0)}, 16'd0, 0, 0, 0);
      send_word(ght_pkg::CMD_POLL, h_a ^ (ID_W'(1) << SLOT_W), 16'd0, 0, 0, 0);
      send_word(ght_pkg::CMD_POLL, '1, 16'd0, 0, 0, 0);
      // A failed command aborts the request only in abort-on-error mode.
      send_word(ght_pkg::CMD_ALLOCATE, '0, 16'd1, 1, 0, 0);
      h_d = board.last_new_id;
      send_word(ght_pkg::CMD_COMPLETE, h_d, 16'd0, 0, 1, 0);
      send_word(ght_pkg::CMD_ALLOCATE, '0, 16'd1, 0, 0, 0);
      h_d = board.last_new_id;
      send_word(ght_pkg::CMD_COMPLETE, h_d, 16'd0, 0, 1, 0);
      pause_sender();
   endtask

   task automatic random_item();
      int              pick, kind, s;
      logic [2:0]      cmd;
      logic [ID_W-1:0] rid;
      logic [15:0]     cnt;
      bit              failed, canceled;
      pick = $urandom_range(99);
      rid = ID_W'($urandom);
      cnt = 16'($urandom);
      failed = 1'($urandom);
      canceled = 1'($urandom);
      cmd = ght_pkg::CMD_ALLOCATE;
      if (pick < 25) begin
         kind = $urandom_range(9);
         if (kind < 7) cnt = 16'($urandom_range(4, 1));
         else if (kind == 9) cnt = '0;
      end else if (pick < 90) begin
         s = live_slot(pick < 60);
         if (s == 0) begin
            cnt = 16'($urandom_range(4, 1));
         end else begin
            rid = board.handle_of(s);
            if (pick < 60) begin
               cmd = ght_pkg::CMD_COMPLETE;
               failed = ($urandom_range(3) == 0);
               canceled = ($urandom_range(7) == 0);
            end else if (pick < 70) begin
               cmd = ght_pkg::CMD_CANCEL;
            end else if (pick < 78) begin
               cmd = ght_pkg::CMD_DELETE;
            end else if (pick < 85) begin
               cmd = ght_pkg::CMD_POLL;
            end else begin
               cmd = ght_pkg::CMD_REMOVE;
            end
         end
      end else begin
         kind = $urandom_range(4);
         cmd = 3'($urandom_range(ght_pkg::CMD_REMOVE, ght_pkg::CMD_COMPLETE));
         case (kind)
            0: rid = '0;
            1: ;
            2: begin
               s = live_slot(0);
               if (s != 0)
                  rid = board.handle_of(s) ^
                        (ID_W'(1) << $urandom_range(ID_W - 1, SLOT_W));
            end
            3: rid[SLOT_W-1:0] = '0;
            default: cmd = ($urandom_range(1) != 0) ? CMD_RESERVED_A : CMD_RESERVED_B;
         endcase
      end
      send_word(cmd, rid, cnt, 1'($urandom), failed, canceled);
   endtask

   task automatic run_phase(int gap, int stall, int items);
      gap_pct = gap;
      stall_pct = stall;
      repeat (items) random_item();
      pause_sender();
   endtask

   // Fills every slot but slot zero with open requests and then hits the full table.
   task automatic fill_table();
      gap_pct = 31;
      stall_pct = 31;
      while (busy_slots() < SLOTS - 1)
         send_word(ght_pkg::CMD_ALLOCATE, ID_W'($urandom), 16'd1, 1'($urandom),
                   1'($urandom), 1'($urandom));
      repeat (3)
         send_word(ght_pkg::CMD_ALLOCATE, ID_W'($urandom), 16'($urandom_range(65535, 1)),
                   1'($urandom), 1'($urandom), 1'($urandom));
      pause_sender();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      directed_checks();
      run_phase(0, 0, 25);
      run_phase(87, 0, 25);
      run_phase(0, 87, 25);
      run_phase(31, 31, 25);
      fill_table();
      gap_pct = 0;
      stall_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d request words and %0d result words.",
               board.n_requests, board.n_results);
      $display("Table found full %0d times; %0d requests settled by completion.",
               board.n_full, board.n_settled);
      if (board.errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
